@@ rtl/core/iirdf1_pkg.sv @@
// Shared types and constants for the direct-form-I IIR filter core.
// Depends on nothing; every other file of the core refers to it by scoped names.
package iirdf1_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEFF_WIDTH     = 24;
   localparam int COEFF_FRAC_BITS = 20;
   localparam int ORDER_MAX       = 3;
   localparam int ORDER_WIDTH     = 2;
   localparam int IN_DEPTH        = ORDER_MAX + 1;
   localparam int OUT_DEPTH       = ORDER_MAX;
   localparam int PROD_WIDTH      = COEFF_WIDTH + SAMPLE_WIDTH;
   // up to seven products plus the rounding bias, with margin
   localparam int ACC_WIDTH       = PROD_WIDTH + 4;
   localparam int ROUND_WIDTH     = ACC_WIDTH - COEFF_FRAC_BITS;
   localparam int STEP_WIDTH      = 3;
   localparam int REG_IDX_WIDTH   = 3;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEFF_WIDTH-1:0]  coeff_type;
   typedef logic [ORDER_WIDTH-1:0]         order_type;
   typedef logic [STEP_WIDTH-1:0]          step_type;
   typedef logic [REG_IDX_WIDTH-1:0]       reg_idx_type;

   // register map
   localparam reg_idx_type REG_FILTER_ORDER = 3'd0;
   localparam reg_idx_type REG_COEFF_B0     = 3'd1;
   localparam reg_idx_type REG_COEFF_B1     = 3'd2;
   localparam reg_idx_type REG_COEFF_B2     = 3'd3;
   localparam reg_idx_type REG_COEFF_B3     = 3'd4;
   localparam reg_idx_type REG_COEFF_A1     = 3'd5;
   localparam reg_idx_type REG_COEFF_A2     = 3'd6;
   localparam reg_idx_type REG_COEFF_A3     = 3'd7;

   localparam coeff_type COEFF_ONE = coeff_type'(1 << COEFF_FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MAC    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     start;   // take the sample, shift input history, clear accumulator
      logic     mul;     // multiply the term selected by step
      step_type step;
      logic     finish;  // round, saturate, load result, push output history
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;    // result register holds an item that is not taken this cycle
   } status_type;

endpackage

@@ rtl/core/iirdf1_if.sv @@
// Channel interfaces of the IIR filter core: sample input, result output and
// register write port. Depends on iirdf1_pkg for payload types.
interface iirdf1_req_if;
   logic                   valid;
   logic                   ready;
   iirdf1_pkg::sample_type sample_in;
   modport source(output valid, output sample_in, input ready);
   modport sink(input valid, input sample_in, output ready);
endinterface

interface iirdf1_rsp_if;
   logic                   valid;
   logic                   ready;
   iirdf1_pkg::sample_type sample_out;
   logic                   saturated;
   modport source(output valid, output sample_out, output saturated, input ready);
   modport sink(input valid, input sample_out, input saturated, output ready);
endinterface

interface iirdf1_csr_if;
   logic                    valid;
   logic                    ready;
   iirdf1_pkg::reg_idx_type reg_index;
   logic [iirdf1_pkg::COEFF_WIDTH-1:0] wdata;
   modport source(output valid, output reg_index, output wdata, input ready);
   modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/core/iir_direct_form_one_filter_core.sv @@
// Top level of the direct-form-I IIR filter core, order 0 to 3.
// Depends on iirdf1_pkg, the channel interfaces, iirdf1_regs, iirdf1_ctrl and iirdf1_dp.
//
// Usage:
//   req_chan  carries one signed 16-bit sample per transfer (valid/ready).
//   rsp_chan  returns one filtered sample and a saturation flag per input sample.
//   csr_chan  writes register reg_index (0 order, 1..4 b0..b3, 5..7 a1..a3);
//             always ready; to be written by the user only while the core is idle, not enforced by the core.
// Timing:
//   One multiplier is shared over the 2*order + 1 taps, one product a cycle,
//   with a registered product feeding the accumulator. After acceptance a
//   sample passes the MAC, drain and finish states, and the result is loaded
//   into the output register in the finish state; the next sample is accepted
//   only once the core is back in idle, so samples are not overlapped.
// Reset (synchronous, active high) clears both histories, sets order 0, b0 to
//   1.0 and all other coefficients to 0, and empties the output register.
// Stall: a pending result is held in the output register while the next sample
//   is accepted and processed; if that one is finished first, the core holds
//   it until the earlier result is transferred.
module iir_direct_form_one_filter_core (
   input logic           clock,
   input logic           reset,
   iirdf1_req_if.sink    req_chan,
   iirdf1_rsp_if.source  rsp_chan,
   iirdf1_csr_if.sink    csr_chan
);

   iirdf1_pkg::order_type  order;
   iirdf1_pkg::coeff_type  coeff_b [0:iirdf1_pkg::ORDER_MAX];
   iirdf1_pkg::coeff_type  coeff_a [1:iirdf1_pkg::ORDER_MAX];
   iirdf1_pkg::cmd_type    cmd;
   iirdf1_pkg::status_type status;
   logic                   req_ready;
   logic                   csr_ready;
   logic                   rsp_valid;
   iirdf1_pkg::sample_type sample_out;
   logic                   saturated;

   iirdf1_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_ready),
      .csr_index (csr_chan.reg_index),
      .csr_wdata (csr_chan.wdata),
      .order     (order),
      .coeff_b   (coeff_b),
      .coeff_a   (coeff_a)
   );

   iirdf1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .order     (order),
      .status    (status),
      .cmd       (cmd)
   );

   iirdf1_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .sample_in  (req_chan.sample_in),
      .coeff_b    (coeff_b),
      .coeff_a    (coeff_a),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .sample_out (sample_out),
      .saturated  (saturated)
   );

   assign req_chan.ready      = req_ready;
   assign csr_chan.ready      = csr_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.sample_out = sample_out;
   assign rsp_chan.saturated  = saturated;

endmodule

@@ rtl/core/iirdf1_regs.sv @@
// Configuration register file of the IIR filter core: filter order and
// the seven Q3.20 coefficients. Depends on iirdf1_pkg.
module iirdf1_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  iirdf1_pkg::reg_idx_type            csr_index,
   input  logic [iirdf1_pkg::COEFF_WIDTH-1:0] csr_wdata,
   output iirdf1_pkg::order_type              order,
   output iirdf1_pkg::coeff_type              coeff_b [0:iirdf1_pkg::ORDER_MAX],
   output iirdf1_pkg::coeff_type              coeff_a [1:iirdf1_pkg::ORDER_MAX]
);

   iirdf1_pkg::order_type order_ff;
   iirdf1_pkg::coeff_type b_ff [0:iirdf1_pkg::ORDER_MAX];
   iirdf1_pkg::coeff_type a_ff [1:iirdf1_pkg::ORDER_MAX];
   logic                  wr_en;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid;

   // decode the write and update the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         b_ff[0]  <= iirdf1_pkg::COEFF_ONE;
         b_ff[1]  <= '0;
         b_ff[2]  <= '0;
         b_ff[3]  <= '0;
         a_ff[1]  <= '0;
         a_ff[2]  <= '0;
         a_ff[3]  <= '0;
      end else if (wr_en) begin
         case (csr_index)
            iirdf1_pkg::REG_FILTER_ORDER: begin
               order_ff <= csr_wdata[iirdf1_pkg::ORDER_WIDTH-1:0];
            end
            iirdf1_pkg::REG_COEFF_B0: b_ff[0] <= csr_wdata;
            iirdf1_pkg::REG_COEFF_B1: b_ff[1] <= csr_wdata;
            iirdf1_pkg::REG_COEFF_B2: b_ff[2] <= csr_wdata;
            iirdf1_pkg::REG_COEFF_B3: b_ff[3] <= csr_wdata;
            iirdf1_pkg::REG_COEFF_A1: a_ff[1] <= csr_wdata;
            iirdf1_pkg::REG_COEFF_A2: a_ff[2] <= csr_wdata;
            iirdf1_pkg::REG_COEFF_A3: a_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign order   = order_ff;
   assign coeff_b = b_ff;
   assign coeff_a = a_ff;

endmodule

@@ rtl/core/iirdf1_ctrl.sv @@
// Sequencer of the IIR filter core: accepts a sample, steps the shared
// multiply-accumulate over the active taps and releases the result.
// Depends on iirdf1_pkg.
module iirdf1_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iirdf1_pkg::order_type  order,
   input  iirdf1_pkg::status_type status,
   output iirdf1_pkg::cmd_type    cmd
);

   iirdf1_pkg::state_type state_ff, state_in;
   iirdf1_pkg::step_type  step_ff, step_in;
   iirdf1_pkg::step_type  last_step;
   logic                  accept;

   // feedforward and feedback terms alternate: 2*order + 1 products
   assign last_step = {order, 1'b0};
   assign req_ready = (state_ff == iirdf1_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         iirdf1_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = iirdf1_pkg::ST_MAC;
               step_in  = '0;
            end
         end
         iirdf1_pkg::ST_MAC: begin
            if (step_ff == last_step) begin
               state_in = iirdf1_pkg::ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         iirdf1_pkg::ST_DRAIN: begin
            state_in = iirdf1_pkg::ST_FINISH;
         end
         iirdf1_pkg::ST_FINISH: begin
            // hold while the previous result still waits
            if (!status.out_busy) begin
               state_in = iirdf1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iirdf1_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iirdf1_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.start  = accept;
      cmd.mul    = (state_ff == iirdf1_pkg::ST_MAC);
      cmd.step   = step_ff;
      cmd.finish = (state_ff == iirdf1_pkg::ST_FINISH) && !status.out_busy;
   end

endmodule

@@ rtl/core/iirdf1_dp.sv @@
// Datapath of the IIR filter core: sample histories, shared multiplier with
// registered product, accumulator, rounding, saturation and result register.
// Depends on iirdf1_pkg.
module iirdf1_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  iirdf1_pkg::sample_type sample_in,
   input  iirdf1_pkg::coeff_type  coeff_b [0:iirdf1_pkg::ORDER_MAX],
   input  iirdf1_pkg::coeff_type  coeff_a [1:iirdf1_pkg::ORDER_MAX],
   input  iirdf1_pkg::cmd_type    cmd,
   output iirdf1_pkg::status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iirdf1_pkg::sample_type sample_out,
   output logic                   saturated
);

   localparam int ACC_W = iirdf1_pkg::ACC_WIDTH;
   localparam int RND_W = iirdf1_pkg::ROUND_WIDTH;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS =
      ACC_W'(1 << (iirdf1_pkg::COEFF_FRAC_BITS - 1));
   localparam logic signed [RND_W-1:0] SAMPLE_MAX =
      RND_W'((1 << (iirdf1_pkg::SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - RND_W'(1);

   iirdf1_pkg::sample_type x_ff [0:iirdf1_pkg::IN_DEPTH-1];
   iirdf1_pkg::sample_type y_ff [0:iirdf1_pkg::OUT_DEPTH-1];

   logic signed [iirdf1_pkg::PROD_WIDTH-1:0] prod_ff;
   logic                                     prod_vld_ff;
   logic                                     prod_sub_ff;
   logic signed [ACC_W-1:0]                  acc_ff, acc_in;

   logic                   rsp_valid_ff;
   iirdf1_pkg::sample_type sample_out_ff;
   logic                   saturated_ff;

   logic [iirdf1_pkg::ORDER_WIDTH-1:0] tap;
   logic [iirdf1_pkg::ORDER_WIDTH-1:0] fb_idx;
   logic                               is_fb;
   iirdf1_pkg::coeff_type              mul_coeff;
   iirdf1_pkg::sample_type             mul_hist;

   logic signed [ACC_W-1:0] biased;
   logic signed [ACC_W-1:0] shifted;
   logic signed [RND_W-1:0] y_wide;
   iirdf1_pkg::sample_type  y_sat;
   logic                    y_clip;

   // term selection: step 0 is b0*x0, odd steps b[k]*x[k], even steps a[k]*y[k-1]
   always_comb begin
      tap       = iirdf1_pkg::ORDER_WIDTH'((cmd.step + 1'b1) >> 1);
      is_fb     = (cmd.step != '0) && !cmd.step[0];
      fb_idx    = tap - 1'b1;
      mul_coeff = is_fb ? coeff_a[tap] : coeff_b[tap];
      mul_hist  = is_fb ? y_ff[fb_idx] : x_ff[tap];
   end

   // shift the new sample into the input history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iirdf1_pkg::IN_DEPTH; i++) begin
            x_ff[i] <= '0;
         end
      end else if (cmd.start) begin
         x_ff[0] <= sample_in;
         for (int i = 1; i < iirdf1_pkg::IN_DEPTH; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
      end
   end

   // register one product per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul;
      end
      prod_ff     <= mul_coeff * mul_hist;
      prod_sub_ff <= is_fb;
   end

   // accumulate the registered product, feedback terms subtracted
   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         if (prod_sub_ff) begin
            acc_in = acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up, drop the fraction bits, clip to the sample range
   always_comb begin
      biased  = acc_ff + ROUND_BIAS;
      shifted = biased >>> iirdf1_pkg::COEFF_FRAC_BITS;
      y_wide  = shifted[RND_W-1:0];
      if (y_wide > SAMPLE_MAX) begin
         y_sat  = SAMPLE_MAX[iirdf1_pkg::SAMPLE_WIDTH-1:0];
         y_clip = 1'b1;
      end else if (y_wide < SAMPLE_MIN) begin
         y_sat  = SAMPLE_MIN[iirdf1_pkg::SAMPLE_WIDTH-1:0];
         y_clip = 1'b1;
      end else begin
         y_sat  = y_wide[iirdf1_pkg::SAMPLE_WIDTH-1:0];
         y_clip = 1'b0;
      end
   end

   // push the clipped output into the feedback history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iirdf1_pkg::OUT_DEPTH; i++) begin
            y_ff[i] <= '0;
         end
      end else if (cmd.finish) begin
         y_ff[0] <= y_sat;
         for (int i = 1; i < iirdf1_pkg::OUT_DEPTH; i++) begin
            y_ff[i] <= y_ff[i-1];
         end
      end
   end

   // result register: load on finish, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         sample_out_ff <= y_sat;
         saturated_ff  <= y_clip;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign sample_out      = sample_out_ff;
   assign saturated       = saturated_ff;

endmodule
